/* rtl/kcl_pkg.sv */
package kcl_pkg;

    // Scan phase codes. The unused code behaves as scanning.
    localparam logic [1:0] PH_SCAN     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_RELEASE  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_UNLOCK_CODE = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE    = 2'd1;

    // Reset values of the configuration registers ("1234" and 20 ticks).
    localparam logic [15:0] UNLOCK_CODE_RST = 16'h4321;
    localparam logic [15:0] DEBOUNCE_RST    = 16'd20;

    // Fixed port geometry of the keypad.
    localparam int InColBits = 3;
    localparam int RowBits   = 4;
    localparam int GridRows  = 4;
    localparam int GridCols  = 3;

    // Key code of star and hash.
    localparam logic [3:0] KEY_STAR = 4'd10;
    localparam logic [3:0] KEY_HASH = 4'd11;

    // One result word.
    typedef struct packed {
        logic [3:0] row_drive;
        logic       key_valid;
        logic [3:0] key_code;
        logic [2:0] keys_entered;
        logic       decided;
        logic       lock_open;
    } kcl_result_t;

    // Key code at a position of the 4x3 grid.
    function automatic logic [3:0] grid_code(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] code;
        code = 4'd0;
        case (row)
            2'd0: code = 4'd1 + 4'(col);
            2'd1: code = 4'd4 + 4'(col);
            2'd2: code = 4'd7 + 4'(col);
            2'd3: begin
                case (col)
                    2'd0:    code = KEY_STAR;
                    2'd1:    code = 4'd0;
                    2'd2:    code = KEY_HASH;
                    default: code = 4'd0;
                endcase
            end
            default: code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

/* rtl/keypad_code_lock.sv */
// Keypad code lock: scans a matrix keypad and checks a key entry against a code.
// A word's result is registered when the word is accepted and shows at m_valid in the next cycle.
// Throughput: one word per cycle while m_ready is high or the single output register is empty.
// Reset (aresetn low, synchronous): scan state, counters, lock and decision clear,
// configuration returns to code "1234" and 20 debounce ticks; stored keys do not reset.
module keypad_code_lock #(
    parameter int NUM_ROWS    = 4,
    parameter int NUM_COLS    = 3,
    parameter int CODE_LENGTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_column_lines,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_row_drive,
    output logic        m_key_valid,
    output logic [3:0]  m_key_code,
    output logic [2:0]  m_keys_entered,
    output logic        m_decided,
    output logic        m_lock_open
);

    localparam int RowW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int ColW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
    localparam int CntW = $clog2(CODE_LENGTH + 1);
    localparam int IdxW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    logic [15:0]              unlock_code_reg;
    logic [15:0]              debounce_reg;
    logic [RowW-1:0]          scan_row_reg, scan_row_next;
    logic [1:0]               phase_reg, phase_next;
    logic [ColW-1:0]          pressed_col_reg, pressed_col_next;
    logic [15:0]              deb_cnt_reg, deb_cnt_next;
    logic [CODE_LENGTH*4-1:0] keys_reg;
    logic [CntW-1:0]          entry_cnt_reg, entry_cnt_next;
    logic                     lock_reg, lock_next;
    logic                     decided_reg, decided_next;
    logic                     key_we;
    logic [3:0]               key_wdata;
    logic                     out_valid_reg;
    kcl_pkg::kcl_result_t     result;
    kcl_pkg::kcl_result_t     res_reg;
    logic                     accept;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Tick logic.
    kcl_step #(
        .NUM_ROWS    (NUM_ROWS),
        .NUM_COLS    (NUM_COLS),
        .CODE_LENGTH (CODE_LENGTH),
        .RowW        (RowW),
        .ColW        (ColW),
        .CntW        (CntW)
    ) u_step (
        .column_lines     (s_column_lines),
        .unlock_code      (unlock_code_reg),
        .debounce_ticks   (debounce_reg),
        .scan_row         (scan_row_reg),
        .phase            (phase_reg),
        .pressed_col      (pressed_col_reg),
        .deb_cnt          (deb_cnt_reg),
        .keys             (keys_reg),
        .entry_cnt        (entry_cnt_reg),
        .lock_state       (lock_reg),
        .decided          (decided_reg),
        .scan_row_next    (scan_row_next),
        .phase_next       (phase_next),
        .pressed_col_next (pressed_col_next),
        .deb_cnt_next     (deb_cnt_next),
        .entry_cnt_next   (entry_cnt_next),
        .lock_state_next  (lock_next),
        .decided_next     (decided_next),
        .key_we           (key_we),
        .key_wdata        (key_wdata),
        .result           (result)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unlock_code_reg <= kcl_pkg::UNLOCK_CODE_RST;
            debounce_reg    <= kcl_pkg::DEBOUNCE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                kcl_pkg::CFG_UNLOCK_CODE: unlock_code_reg <= cfg_wdata;
                kcl_pkg::CFG_DEBOUNCE:    debounce_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Scan and entry state, updated on each accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_row_reg    <= '0;
            phase_reg       <= kcl_pkg::PH_SCAN;
            pressed_col_reg <= '0;
            deb_cnt_reg     <= '0;
            entry_cnt_reg   <= '0;
            lock_reg        <= 1'b0;
            decided_reg     <= 1'b0;
        end else if (accept) begin
            scan_row_reg    <= scan_row_next;
            phase_reg       <= phase_next;
            pressed_col_reg <= pressed_col_next;
            deb_cnt_reg     <= deb_cnt_next;
            entry_cnt_reg   <= entry_cnt_next;
            lock_reg        <= lock_next;
            decided_reg     <= decided_next;
        end
    end

    // Entered keys need no reset; a slot is read only after it is written.
    always_ff @(posedge aclk) begin
        if (accept && key_we) begin
            keys_reg[4*IdxW'(entry_cnt_reg) +: 4] <= key_wdata;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_row_drive    = res_reg.row_drive;
    assign m_key_valid    = res_reg.key_valid;
    assign m_key_code     = res_reg.key_code;
    assign m_keys_entered = res_reg.keys_entered;
    assign m_decided      = res_reg.decided;
    assign m_lock_open    = res_reg.lock_open;

`ifndef SYNTHESIS
    // Once decided, the block stays decided until reset.
    a_decided_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        decided_reg |=> decided_reg)
        else $error("decision was dropped");

    // An open lock always follows a decision.
    a_open_needs_decision: assert property (@(posedge aclk) disable iff (!aresetn)
        lock_reg |-> decided_reg)
        else $error("lock open without decision");

    // A decided result word drives no keypad row.
    a_decided_rows_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && decided_reg |=> m_valid && m_row_drive == 4'hF && !m_key_valid)
        else $error("keypad scanned after decision");
`endif

endmodule

/* rtl/kcl_step.sv */
module kcl_step #(
    parameter int NUM_ROWS    = 4,
    parameter int NUM_COLS    = 3,
    parameter int CODE_LENGTH = 4,
    parameter int RowW        = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1,
    parameter int ColW        = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1,
    parameter int CntW        = $clog2(CODE_LENGTH + 1)
) (
    input  logic [2:0]               column_lines,
    input  logic [15:0]              unlock_code,
    input  logic [15:0]              debounce_ticks,
    input  logic [RowW-1:0]          scan_row,
    input  logic [1:0]               phase,
    input  logic [ColW-1:0]          pressed_col,
    input  logic [15:0]              deb_cnt,
    input  logic [CODE_LENGTH*4-1:0] keys,
    input  logic [CntW-1:0]          entry_cnt,
    input  logic                     lock_state,
    input  logic                     decided,
    output logic [RowW-1:0]          scan_row_next,
    output logic [1:0]               phase_next,
    output logic [ColW-1:0]          pressed_col_next,
    output logic [15:0]              deb_cnt_next,
    output logic [CntW-1:0]          entry_cnt_next,
    output logic                     lock_state_next,
    output logic                     decided_next,
    output logic                     key_we,
    output logic [3:0]               key_wdata,
    output kcl_pkg::kcl_result_t     result
);

    logic [7:0]  cols_ext;
    logic [31:0] code_ext;
    logic [3:0]  rows;
    logic        hit;
    logic [ColW-1:0] hit_col;
    logic        valid;
    logic [3:0]  code;
    logic        match;
    logic [3:0]  key_i;
    logic [15:0] deb_dec;

    // Columns without an input bit read as released.
    assign cols_ext = {5'b11111, column_lines};
    assign code_ext = {16'd0, unlock_code};

    // First pressed column among the scanned ones.
    always_comb begin
        hit     = 1'b0;
        hit_col = '0;
        for (int c = NUM_COLS - 1; c >= 0; c--) begin
            if (!cols_ext[c]) begin
                hit     = 1'b1;
                hit_col = ColW'(c);
            end
        end
    end

    // Compare the entry, with the key of this tick in its slot.
    always_comb begin
        match = 1'b1;
        key_i = 4'd0;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            key_i = (CntW'(i) == entry_cnt) ? code : keys[4*i +: 4];
            if (key_i != code_ext[4*i +: 4]) begin
                match = 1'b0;
            end
        end
    end

    assign deb_dec = (deb_cnt != 16'd0) ? deb_cnt - 16'd1 : deb_cnt;

    // Scan sequencer for one tick.
    always_comb begin
        scan_row_next    = scan_row;
        phase_next       = phase;
        pressed_col_next = pressed_col;
        deb_cnt_next     = deb_cnt;
        entry_cnt_next   = entry_cnt;
        lock_state_next  = lock_state;
        decided_next     = decided;
        key_we           = 1'b0;
        key_wdata        = 4'd0;
        valid            = 1'b0;
        code             = 4'd0;
        rows             = 4'hF;
        if (!decided) begin
            if (4'(scan_row) < 4'(kcl_pkg::RowBits)) begin
                rows = 4'hF & ~(4'd1 << scan_row);
            end
            case (phase)
                kcl_pkg::PH_DEBOUNCE: begin
                    deb_cnt_next = deb_dec;
                    if (deb_dec == 16'd0) begin
                        phase_next = kcl_pkg::PH_RELEASE;
                    end
                end
                kcl_pkg::PH_RELEASE: begin
                    if (cols_ext[3'(pressed_col)]) begin
                        phase_next    = kcl_pkg::PH_SCAN;
                        scan_row_next = '0;
                        if (4'(scan_row) < 4'(kcl_pkg::GridRows)
                                && 4'(pressed_col) < 4'(kcl_pkg::GridCols)) begin
                            valid = 1'b1;
                            code  = kcl_pkg::grid_code(2'(scan_row), 2'(pressed_col));
                            if (entry_cnt < CntW'(CODE_LENGTH)) begin
                                key_we         = 1'b1;
                                key_wdata      = code;
                                entry_cnt_next = entry_cnt + CntW'(1);
                            end
                            if (entry_cnt_next >= CntW'(CODE_LENGTH)) begin
                                lock_state_next = match;
                                decided_next    = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    phase_next = kcl_pkg::PH_SCAN;
                    if (hit) begin
                        pressed_col_next = hit_col;
                        if (debounce_ticks == 16'd0) begin
                            phase_next = kcl_pkg::PH_RELEASE;
                        end else begin
                            deb_cnt_next = debounce_ticks;
                            phase_next   = kcl_pkg::PH_DEBOUNCE;
                        end
                    end else if (scan_row == RowW'(NUM_ROWS - 1)) begin
                        scan_row_next = '0;
                    end else begin
                        scan_row_next = scan_row + RowW'(1);
                    end
                end
            endcase
        end
        result.row_drive    = rows;
        result.key_valid    = valid;
        result.key_code     = code;
        result.keys_entered = 3'(entry_cnt_next);
        result.decided      = decided_next;
        result.lock_open    = lock_state_next;
    end

endmodule

/* verif/keypad_code_lock_tb.sv */
module keypad_code_lock_tb;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 250;

    // Key codes laid out as on the keypad face, indexed by row and column.
    localparam logic [3:0] KEY_MAP [4][3] = '{
        '{4'd1, 4'd2, 4'd3},
        '{4'd4, 4'd5, 4'd6},
        '{4'd7, 4'd8, 4'd9},
        '{kcl_pkg::KEY_STAR, 4'd0, kcl_pkg::KEY_HASH}
    };

    // Tracks the scanner and the entry, and keeps the scan reports still due.
    class code_lock_checker;
        logic [15:0] code_reg;
        logic [15:0] debounce_reg;
        logic [1:0]  row;
        logic [1:0]  phase;
        logic [1:0]  held_col;
        logic [15:0] countdown;
        logic [3:0]  typed [4];
        logic [2:0]  typed_cnt;
        logic        opened;
        logic        done;
        kcl_pkg::kcl_result_t reports [$];
        int          faults;

        function new();
            code_reg     = kcl_pkg::UNLOCK_CODE_RST;
            debounce_reg = kcl_pkg::DEBOUNCE_RST;
            row          = 2'd0;
            phase        = kcl_pkg::PH_SCAN;
            held_col     = 2'd0;
            countdown    = 16'd0;
            typed_cnt    = 3'd0;
            opened       = 1'b0;
            done         = 1'b0;
            faults       = 0;
        endfunction

        // Advance the scanner by one accepted column word and queue its report.
        function void take_scan(logic [2:0] cols);
            kcl_pkg::kcl_result_t report;
            logic hit;
            report = '0;
            report.row_drive = 4'hF;
            if (!done) begin
                report.row_drive[row] = 1'b0;
                case (phase)
                    kcl_pkg::PH_DEBOUNCE: begin
                        if (countdown != 16'd0) countdown--;
                        if (countdown == 16'd0) phase = kcl_pkg::PH_RELEASE;
                    end
                    kcl_pkg::PH_RELEASE: begin
                        // The key counts once its column reads high again.
                        if (cols[held_col]) begin
                            report.key_valid = 1'b1;
                            report.key_code  = KEY_MAP[row][held_col];
                            typed[typed_cnt] = report.key_code;
                            typed_cnt++;
                            if (typed_cnt == 3'd4) begin
                                // First key typed sits in the low nibble of the code.
                                opened = 1'b1;
                                for (int i = 0; i < 4; i++) begin
                                    if (typed[i] != code_reg[4*i +: 4]) opened = 1'b0;
                                end
                                done = 1'b1;
                            end
                            phase = kcl_pkg::PH_SCAN;
                            row   = 2'd0;
                        end
                    end
                    default: begin
                        // Lowest numbered low column wins; otherwise move to the next row.
                        hit   = 1'b0;
                        phase = kcl_pkg::PH_SCAN;
                        for (int c = 0; c < 3; c++) begin
                            if (!hit && !cols[c]) begin
                                hit      = 1'b1;
                                held_col = 2'(c);
                            end
                        end
                        if (!hit) begin
                            row++;
                        end else if (debounce_reg == 16'd0) begin
                            phase = kcl_pkg::PH_RELEASE;
                        end else begin
                            countdown = debounce_reg;
                            phase     = kcl_pkg::PH_DEBOUNCE;
                        end
                    end
                endcase
            end
            report.keys_entered = typed_cnt;
            report.decided      = done;
            report.lock_open    = opened;
            reports.push_back(report);
        endfunction

        function void flag(string what, int want, int got);
            faults++;
            if (faults <= 10)
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        endfunction

        // Compare one result word with the oldest report still due.
        function void match_report(kcl_pkg::kcl_result_t got);
            kcl_pkg::kcl_result_t want;
            if (reports.size() == 0) begin
                faults++;
                if (faults <= 10) $display("result word arrived with none due: %p", got);
                return;
            end
            want = reports.pop_front();
            if (got.row_drive != want.row_drive)
                flag("row_drive", want.row_drive, got.row_drive);
            if (got.key_valid != want.key_valid)
                flag("key_valid", want.key_valid, got.key_valid);
            if (got.key_code != want.key_code)
                flag("key_code", want.key_code, got.key_code);
            if (got.keys_entered != want.keys_entered)
                flag("keys_entered", want.keys_entered, got.keys_entered);
            if (got.decided != want.decided)
                flag("decided", want.decided, got.decided);
            if (got.lock_open != want.lock_open)
                flag("lock_open", want.lock_open, got.lock_open);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_column_lines;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_row_drive;
    logic        m_key_valid;
    logic [3:0]  m_key_code;
    logic [2:0]  m_keys_entered;
    logic        m_decided;
    logic        m_lock_open;

    code_lock_checker sb = new();
    logic calm;
    int   cycles = 0;

    keypad_code_lock dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_column_lines (s_column_lines),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_drive    (m_row_drive),
        .m_key_valid    (m_key_valid),
        .m_key_code     (m_key_code),
        .m_keys_entered (m_keys_entered),
        .m_decided      (m_decided),
        .m_lock_open    (m_lock_open)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("keypad_code_lock_tb: errors");
            $finish;
        end
    end

    // Watch both channels at the rising edge.
    always @(posedge aclk) begin
        kcl_pkg::kcl_result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.row_drive    = m_row_drive;
            seen.key_valid    = m_key_valid;
            seen.key_code     = m_key_code;
            seen.keys_entered = m_keys_entered;
            seen.decided      = m_decided;
            seen.lock_open    = m_lock_open;
            sb.match_report(seen);
        end
        if (aresetn && s_valid && s_ready) sb.take_scan(s_column_lines);
    end

    function automatic int pick_wait();
        if (calm) return 0;
        return $urandom_range(0, 13);
    endfunction

    // Result side: random stalls, with two long hold-offs so the block backs up.
    initial begin
        int stall;
        int taken;
        taken   = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = pick_wait();
            if (taken == 300 || taken == 600) stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            @(negedge aclk);
        end
    end

    // Offer one column word and hold it until it is taken.
    task automatic send_word(input logic [2:0] cols);
        int gap;
        gap = pick_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_column_lines <= cols;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic scan_idle(input int count);
        repeat (count) send_word(3'b111);
    endtask

    task automatic noise(input int count);
        repeat (count) send_word(3'($urandom));
    endtask

    // Press the key at (r, c): wait for its row, press, bounce through the
    // debounce wait, hold for a while, then release.
    task automatic press_key(input logic [1:0] r, input logic [1:0] c,
                             input logic [2:0] fill, input int hold);
        logic [2:0] w;
        logic [2:0] below;
        below = 3'((1 << c) - 1);
        while (!(sb.phase == kcl_pkg::PH_SCAN && sb.row == r)) send_word(3'b111);
        w = (fill & ~below) | below;
        w[c] = 1'b0;
        send_word(w);
        while (sb.phase == kcl_pkg::PH_DEBOUNCE) send_word(3'($urandom));
        repeat (hold) begin
            w = 3'($urandom);
            w[c] = 1'b0;
            send_word(w);
        end
        w = 3'($urandom);
        w[c] = 1'b1;
        send_word(w);
    endtask

    // Stop offering and wait until every report has come back.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.reports.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            kcl_pkg::CFG_UNLOCK_CODE: sb.code_reg = data;
            default:                  sb.debounce_reg = data;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [1:0]  krow [4];
        logic [1:0]  kcol [4];
        logic [15:0] entry_code;
        logic        want_match;
        int          i;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_column_lines = 3'b111;
        cfg_we         = 1'b0;
        cfg_index      = kcl_pkg::CFG_UNLOCK_CODE;
        cfg_wdata      = 16'd0;
        calm           = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Only one entry is decided per reset, so pick the four keys up front
        // and build a code that either matches them or differs in one nibble.
        for (i = 0; i < 4; i++) begin
            krow[i] = 2'($urandom_range(0, 3));
            kcol[i] = 2'($urandom_range(0, 2));
            entry_code[4*i +: 4] = KEY_MAP[krow[i]][kcol[i]];
        end
        want_match = 1'($urandom_range(0, 1));
        if (!want_match) begin
            i = $urandom_range(0, 3);
            entry_code[4*i +: 4] ^= 4'($urandom_range(1, 15));
        end

        // Directed: row rotation, zero debounce with an immediate release and
        // the columns above the key also low, then a short debounce with a held key.
        write_reg(kcl_pkg::CFG_DEBOUNCE, 16'd0);
        scan_idle(5);
        press_key(krow[0], kcol[0], 3'b000, 0);
        settle();
        write_reg(kcl_pkg::CFG_DEBOUNCE, 16'd2);
        press_key(krow[1], kcol[1], 3'b111, 3);

        // Largest register values while the keypad stays quiet.
        settle();
        write_reg(kcl_pkg::CFG_UNLOCK_CODE, 16'hFFFF);
        write_reg(kcl_pkg::CFG_DEBOUNCE, 16'hFFFF);
        calm = 1'($urandom_range(0, 1));
        scan_idle($urandom_range(40, 80));

        // Third key with a long, noisy debounce wait.
        settle();
        calm = 1'b0;
        write_reg(kcl_pkg::CFG_UNLOCK_CODE, 16'h0000);
        write_reg(kcl_pkg::CFG_DEBOUNCE, 16'($urandom_range(150, 330)));
        scan_idle($urandom_range(20, 60));
        press_key(krow[2], kcol[2], 3'($urandom), $urandom_range(20, 80));

        // Last key decides the entry against the final code.
        settle();
        write_reg(kcl_pkg::CFG_UNLOCK_CODE, entry_code);
        write_reg(kcl_pkg::CFG_DEBOUNCE, 16'($urandom_range(150, 330)));
        calm = 1'b1;
        scan_idle($urandom_range(20, 60));
        calm = 1'b0;
        press_key(krow[3], kcol[3], 3'($urandom), $urandom_range(20, 80));

        // After the decision every word must leave the lock as it is.
        noise(80);
        settle();
        write_reg(kcl_pkg::CFG_DEBOUNCE, 16'd0);
        write_reg(kcl_pkg::CFG_UNLOCK_CODE, 16'($urandom));
        noise(40);

        settle();
        repeat (4) @(negedge aclk);
        if (sb.faults == 0 && sb.reports.size() == 0)
            $display("keypad_code_lock_tb: clean");
        else
            $display("keypad_code_lock_tb: errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/kcl_pkg.sv
rtl/kcl_step.sv
rtl/keypad_code_lock.sv
verif/keypad_code_lock_tb.sv
